/* rtl/core/assert_macros.svh */
// Assertion macros used by the report engine of the keyboard report builder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define HKRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define HKRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/hkrb_pkg.sv */
// Package with types, constants and the ASCII map of the keyboard report builder.
`timescale 1ns / 1ps
`default_nettype none
package hkrb_pkg;

  localparam int unsigned KEY_SLOTS      = 6;
  localparam int unsigned REPORT_SLOTS   = 6;
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned PADDR_W        = 3;

  localparam logic [7:0] SHIFT_MASK_RESET = 8'h02;
  localparam logic [7:0] PAGE_MODIFIER    = 8'hE0;
  localparam logic [7:0] PAGE_ASCII       = 8'h00;

  localparam logic [0:0] REG_SHIFT_MASK = 1'b0;

  localparam logic [7:0] USAGE_NONE      = 8'h00;
  localparam logic [7:0] USAGE_A         = 8'h04;
  localparam logic [7:0] USAGE_1         = 8'h1E;
  localparam logic [7:0] USAGE_0         = 8'h27;
  localparam logic [7:0] USAGE_ENTER     = 8'h28;
  localparam logic [7:0] USAGE_TAB       = 8'h2B;
  localparam logic [7:0] USAGE_SPACE     = 8'h2C;
  localparam logic [7:0] USAGE_MINUS     = 8'h2D;
  localparam logic [7:0] USAGE_EQUAL     = 8'h2E;
  localparam logic [7:0] USAGE_LBRACKET  = 8'h2F;
  localparam logic [7:0] USAGE_RBRACKET  = 8'h30;
  localparam logic [7:0] USAGE_BACKSLASH = 8'h31;
  localparam logic [7:0] USAGE_SEMICOLON = 8'h33;
  localparam logic [7:0] USAGE_QUOTE     = 8'h34;
  localparam logic [7:0] USAGE_GRAVE     = 8'h35;
  localparam logic [7:0] USAGE_COMMA     = 8'h36;
  localparam logic [7:0] USAGE_PERIOD    = 8'h37;
  localparam logic [7:0] USAGE_SLASH     = 8'h38;

  typedef enum logic [1:0] {
    MODE_PRESS       = 2'd0,
    MODE_RELEASE     = 2'd1,
    MODE_RELEASE_ALL = 2'd2,
    MODE_TYPE_CHAR   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_PRESS,
    OP_RELEASE_MOD,
    OP_RELEASE_KEY,
    OP_CLEAR,
    OP_TYPE
  } op_e;

  typedef enum logic {
    BK_RUN,
    BK_SECOND
  } back_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] bits;
    logic [7:0] usage;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic [7:0] usage;
    logic       upper;
  } ascii_map_t;

  function automatic ascii_map_t ascii_map(input logic [7:0] ch);
    ascii_map_t r;
    r.usage = USAGE_NONE;
    r.upper = 1'b0;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      r.usage = USAGE_A + (ch - 8'h61);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      r.usage = USAGE_A + (ch - 8'h41);
      r.upper = 1'b1;
    end else if (ch >= 8'h31 && ch <= 8'h39) begin
      r.usage = USAGE_1 + (ch - 8'h31);
    end else begin
      unique case (ch)
        8'h30:         r.usage = USAGE_0;
        8'h20:         r.usage = USAGE_SPACE;
        8'h0A, 8'h0D:  r.usage = USAGE_ENTER;
        8'h09:         r.usage = USAGE_TAB;
        8'h2D:         r.usage = USAGE_MINUS;
        8'h3D:         r.usage = USAGE_EQUAL;
        8'h5B:         r.usage = USAGE_LBRACKET;
        8'h5D:         r.usage = USAGE_RBRACKET;
        8'h5C:         r.usage = USAGE_BACKSLASH;
        8'h3B:         r.usage = USAGE_SEMICOLON;
        8'h27:         r.usage = USAGE_QUOTE;
        8'h60:         r.usage = USAGE_GRAVE;
        8'h2C:         r.usage = USAGE_COMMA;
        8'h2E:         r.usage = USAGE_PERIOD;
        8'h2F:         r.usage = USAGE_SLASH;
        default:       r.usage = USAGE_NONE;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/hkrb_cmd_fifo.sv */
// Short command queue between the classifying front end and the report engine.
`timescale 1ns / 1ps
`default_nettype none
module hkrb_cmd_fifo #(
  parameter int unsigned Depth = hkrb_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire hkrb_pkg::cmd_t        push_cmd_i,
  input  wire logic                  pop_i,
  output hkrb_pkg::cmd_t             head_cmd_o,
  output hkrb_pkg::fifo_status_t     status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hkrb_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/hkrb_front.sv */
// Front end that takes key events and turns them into report engine commands.
`timescale 1ns / 1ps
`default_nettype none
module hkrb_front (
  input  wire logic                  start_i,
  input  wire logic [1:0]            mode_i,
  input  wire logic [15:0]           key_code_i,
  input  wire logic [7:0]            shift_mask_i,
  input  wire hkrb_pkg::fifo_status_t fifo_status_i,
  output logic                       busy_o,
  output logic                       push_o,
  output hkrb_pkg::cmd_t             cmd_o
);

  logic [7:0]           page;
  logic [7:0]           low;
  hkrb_pkg::ascii_map_t amap;
  logic [7:0]           shift_bits;
  logic                 keep;

  assign page       = key_code_i[15:8];
  assign low        = key_code_i[7:0];
  assign amap       = hkrb_pkg::ascii_map(low);
  assign shift_bits = amap.upper ? shift_mask_i : 8'h00;
  assign busy_o     = fifo_status_i.full;

  always_comb begin
    cmd_o.op    = hkrb_pkg::OP_CLEAR;
    cmd_o.bits  = 8'h00;
    cmd_o.usage = hkrb_pkg::USAGE_NONE;
    keep        = 1'b1;
    unique case (hkrb_pkg::mode_e'(mode_i))
      hkrb_pkg::MODE_PRESS: begin
        cmd_o.op = hkrb_pkg::OP_PRESS;
        if (page == hkrb_pkg::PAGE_MODIFIER) begin
          cmd_o.bits = low;
        end else if (page == hkrb_pkg::PAGE_ASCII) begin
          cmd_o.bits  = shift_bits;
          cmd_o.usage = amap.usage;
        end else begin
          cmd_o.usage = low;
        end
      end
      hkrb_pkg::MODE_RELEASE: begin
        if (page == hkrb_pkg::PAGE_MODIFIER) begin
          cmd_o.op   = hkrb_pkg::OP_RELEASE_MOD;
          cmd_o.bits = low;
        end else begin
          cmd_o.op    = hkrb_pkg::OP_RELEASE_KEY;
          cmd_o.usage = low;
        end
      end
      hkrb_pkg::MODE_RELEASE_ALL: begin
        cmd_o.op = hkrb_pkg::OP_CLEAR;
      end
      hkrb_pkg::MODE_TYPE_CHAR: begin
        cmd_o.op    = hkrb_pkg::OP_TYPE;
        cmd_o.bits  = shift_bits;
        cmd_o.usage = amap.usage;
        keep        = (amap.usage != hkrb_pkg::USAGE_NONE);
      end
      default: begin
        cmd_o.op = hkrb_pkg::OP_CLEAR;
      end
    endcase
  end

  // A typed character without a usage produces no report and is dropped here.
  assign push_o = start_i && !fifo_status_i.full && keep;

endmodule
`default_nettype wire

/* rtl/core/hkrb_back.sv */
// Report engine that holds the keyboard state and emits the reports.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hkrb_back #(
  parameter int unsigned KeySlots = hkrb_pkg::KEY_SLOTS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hkrb_pkg::cmd_t         cmd_i,
  input  wire hkrb_pkg::fifo_status_t fifo_status_i,
  output logic                        pop_o,
  output logic                        report_valid_o,
  output logic [7:0]                  modifiers_o,
  output logic [7:0]                  slots_o [hkrb_pkg::REPORT_SLOTS],
  output logic                        last_report_o
);

  localparam int unsigned RptSlots   = hkrb_pkg::REPORT_SLOTS;
  localparam int unsigned ShownSlots = (KeySlots < RptSlots) ? KeySlots : RptSlots;

  hkrb_pkg::back_state_e st_q, st_d;

  logic [7:0]          mods_q, mods_d;
  logic [7:0]          keys_q [KeySlots];
  logic [7:0]          keys_d [KeySlots];
  logic [7:0]          shifted [KeySlots];
  logic [KeySlots-1:0] eq;
  logic [KeySlots-1:0] nz;
  logic [KeySlots-1:0] prev_nz;
  logic [KeySlots-1:0] after;
  logic                dup;
  logic                first_type;

  logic                rpt_valid;
  logic [7:0]          rpt_mods;
  logic [7:0]          rpt_slots [RptSlots];
  logic                rpt_last;

  logic                valid_q;
  logic [7:0]          rmods_q;
  logic [7:0]          rslots_q [RptSlots];
  logic                last_q;
  logic                packed_ok;

  // Held keys always form a packed run from slot zero, so the first free slot
  // follows the last used one, and removing a key shifts the tail down.
  for (genvar i = 0; i < KeySlots; i++) begin : g_slot
    assign eq[i] = (keys_q[i] == cmd_i.usage);
    assign nz[i] = (keys_q[i] != 8'h00);
    if (i == 0) begin : g_first
      assign prev_nz[i] = 1'b1;
      assign after[i]   = eq[i];
    end else begin : g_rest
      assign prev_nz[i] = nz[i-1];
      assign after[i]   = after[i-1] | eq[i];
    end
    if (i == KeySlots - 1) begin : g_tail
      assign shifted[i] = 8'h00;
    end else begin : g_body
      assign shifted[i] = keys_q[i+1];
    end
  end

  assign dup        = |eq;
  assign first_type = (st_q == hkrb_pkg::BK_RUN) && (cmd_i.op == hkrb_pkg::OP_TYPE);

  always_comb begin
    mods_d = mods_q;
    for (int i = 0; i < KeySlots; i++) begin
      keys_d[i] = keys_q[i];
    end
    unique case (cmd_i.op)
      hkrb_pkg::OP_PRESS: begin
        mods_d = mods_q | cmd_i.bits;
        for (int i = 0; i < KeySlots; i++) begin
          if (cmd_i.usage != hkrb_pkg::USAGE_NONE && !dup && !nz[i] && prev_nz[i]) begin
            keys_d[i] = cmd_i.usage;
          end
        end
      end
      hkrb_pkg::OP_RELEASE_MOD: begin
        mods_d = mods_q & ~cmd_i.bits;
      end
      hkrb_pkg::OP_RELEASE_KEY: begin
        for (int i = 0; i < KeySlots; i++) begin
          if (after[i]) begin
            keys_d[i] = shifted[i];
          end
        end
      end
      hkrb_pkg::OP_CLEAR: begin
        mods_d = 8'h00;
        for (int i = 0; i < KeySlots; i++) begin
          keys_d[i] = 8'h00;
        end
      end
      hkrb_pkg::OP_TYPE: begin
        mods_d = mods_q;
      end
      default: begin
        mods_d = mods_q;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      hkrb_pkg::BK_RUN: begin
        if (!fifo_status_i.empty && cmd_i.op == hkrb_pkg::OP_TYPE) begin
          st_d = hkrb_pkg::BK_SECOND;
        end
      end
      hkrb_pkg::BK_SECOND: begin
        st_d = hkrb_pkg::BK_RUN;
      end
      default: begin
        st_d = hkrb_pkg::BK_RUN;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < RptSlots; j++) begin
      rpt_slots[j] = 8'h00;
    end
    if (first_type) begin
      rpt_slots[0] = cmd_i.usage;
    end else begin
      for (int j = 0; j < ShownSlots; j++) begin
        rpt_slots[j] = keys_d[j];
      end
    end
  end

  always_comb begin
    rpt_valid = !fifo_status_i.empty;
    pop_o     = !fifo_status_i.empty && !first_type;
    rpt_mods  = first_type ? (mods_q | cmd_i.bits) : mods_d;
    rpt_last  = !first_type;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= hkrb_pkg::BK_RUN;
      valid_q <= 1'b0;
      mods_q  <= 8'h00;
      for (int i = 0; i < KeySlots; i++) begin
        keys_q[i] <= 8'h00;
      end
    end else begin
      st_q    <= st_d;
      valid_q <= rpt_valid;
      if (pop_o) begin
        mods_q <= mods_d;
        for (int i = 0; i < KeySlots; i++) begin
          keys_q[i] <= keys_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpt_valid) begin
      rmods_q <= rpt_mods;
      last_q  <= rpt_last;
      for (int j = 0; j < RptSlots; j++) begin
        rslots_q[j] <= rpt_slots[j];
      end
    end
  end

  assign report_valid_o = valid_q;
  assign modifiers_o    = rmods_q;
  assign slots_o        = rslots_q;
  assign last_report_o  = last_q;

  always_comb begin
    packed_ok = 1'b1;
    for (int i = 0; i < KeySlots; i++) begin
      if (nz[i] && !prev_nz[i]) begin
        packed_ok = 1'b0;
      end
    end
  end

  `HKRB_ASSERT_ALWAYS(a_keys_packed, clk_i, packed_ok, "held keys are not packed")
  `HKRB_ASSERT(a_second_report, clk_i, rst_ni,
    (st_q == hkrb_pkg::BK_SECOND) |=> (valid_q && last_q), "missing restore report")
  `HKRB_ASSERT(a_first_report, clk_i, rst_ni,
    (valid_q && !last_q) |-> (st_q == hkrb_pkg::BK_SECOND), "press report without restore")

endmodule
`default_nettype wire

/* rtl/core/hid_keyboard_report_builder.sv */
// Top level of the USB HID boot keyboard report builder.
`timescale 1ns / 1ps
`default_nettype none
// Keyboard report builder with six reported key slots and one modifier byte.
// Key events enter on start with mode_i and key_code_i; an event transfer
// happens at a clock edge with start high and busy low. Each report leaves
// as a transfer of one cycle marked by report_valid_o; last_report_o is high
// on the final report of an event. The receiver must always take the report;
// the block does not wait for it. A two-entry command queue separates event
// decoding from the report engine; an event is registered in the queue and
// its first report is registered at the engine output. Press, release and
// release-all produce one report; type-char produces a press report and then
// a restore report. A type-char of an unmapped character produces no report.
// busy rises only when the command queue is full.
// The shift modifier mask sits at byte address 0 of the APB port; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset clears the held modifiers, all key slots, the queue and sets the
// shift modifier mask to 0x02.
module hid_keyboard_report_builder #(
  parameter int unsigned KeySlots = hkrb_pkg::KEY_SLOTS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hkrb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [15:0]                   key_code_i,
  output logic                               report_valid_o,
  output logic [7:0]                         modifiers_o,
  output logic [7:0]                         key_slot_0_o,
  output logic [7:0]                         key_slot_1_o,
  output logic [7:0]                         key_slot_2_o,
  output logic [7:0]                         key_slot_3_o,
  output logic [7:0]                         key_slot_4_o,
  output logic [7:0]                         key_slot_5_o,
  output logic                               last_report_o
);

  logic [7:0]             shift_mask_q, shift_mask_d;
  logic                   reg_sel;
  logic                   push;
  logic                   pop;
  hkrb_pkg::cmd_t         push_cmd;
  hkrb_pkg::cmd_t         head_cmd;
  hkrb_pkg::fifo_status_t fifo_status;
  logic [7:0]             slots [hkrb_pkg::REPORT_SLOTS];

  assign pready  = 1'b1;
  assign reg_sel = (paddr[hkrb_pkg::PADDR_W-1] == hkrb_pkg::REG_SHIFT_MASK);
  assign prdata  = reg_sel ? {24'h000000, shift_mask_q} : 32'h00000000;

  always_comb begin
    shift_mask_d = shift_mask_q;
    if (psel && penable && pwrite && reg_sel) begin
      shift_mask_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_mask_q <= hkrb_pkg::SHIFT_MASK_RESET;
    end else begin
      shift_mask_q <= shift_mask_d;
    end
  end

  hkrb_front u_front (
    .start_i       (start),
    .mode_i        (mode_i),
    .key_code_i    (key_code_i),
    .shift_mask_i  (shift_mask_q),
    .fifo_status_i (fifo_status),
    .busy_o        (busy),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  hkrb_cmd_fifo #(
    .Depth (hkrb_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .status_o   (fifo_status)
  );

  hkrb_back #(
    .KeySlots (KeySlots)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .fifo_status_i  (fifo_status),
    .pop_o          (pop),
    .report_valid_o (report_valid_o),
    .modifiers_o    (modifiers_o),
    .slots_o        (slots),
    .last_report_o  (last_report_o)
  );

  assign key_slot_0_o = slots[0];
  assign key_slot_1_o = slots[1];
  assign key_slot_2_o = slots[2];
  assign key_slot_3_o = slots[3];
  assign key_slot_4_o = slots[4];
  assign key_slot_5_o = slots[5];

endmodule
`default_nettype wire
